>>> rtl/e2q_pkg.sv
// Shared constants, types and the arctangent table for the Euler-to-quaternion block.
package e2q_pkg;

  localparam int IN_W      = 27;
  localparam int OUT_W     = 18;
  localparam int FRAC_BITS = 16;
  localparam int ANG_W     = 34;
  localparam int SC_W      = 32;
  localparam int R_W       = 24;

  // Angle reduction constants, in degrees with FRAC_BITS fraction bits.
  localparam int PERIOD  = 720 * (1 << FRAC_BITS);
  localparam int QUARTER = 180 * (1 << FRAC_BITS);
  localparam int HALF_Q  = QUARTER / 2;

  // Degrees to radians as round(pi/180 * 2^40), split for two narrow multiplies.
  localparam longint DEG2RAD   = 64'd19190098069;
  localparam int     D2R_SPLIT = 17;
  localparam int     D2R_HI_W  = 18;
  localparam logic [D2R_HI_W-1:0]  D2R_HI = D2R_HI_W'(DEG2RAD >> D2R_SPLIT);
  localparam logic [D2R_SPLIT-1:0] D2R_LO = D2R_SPLIT'(DEG2RAD);
  localparam int     RAD_SHIFT = FRAC_BITS + 11;

  localparam logic [31:0] CORDIC_INIT_X = 32'h26DD3B6A;

  typedef struct packed {
    logic signed [SC_W-1:0] c;
    logic signed [SC_W-1:0] s;
  } sc_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] k;
    logic signed [OUT_W-1:0] j;
    logic signed [OUT_W-1:0] i;
    logic signed [OUT_W-1:0] w;
  } quat_t;

  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] v;
    unique case (idx)
      0:  v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD; 10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
      18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
      21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
      24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
      27: v = 32'h00000007; 28: v = 32'h00000003; 29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/euler_degrees_to_quaternion.sv
// Top level: ZYX Euler angles in degrees to a unit quaternion, fully pipelined.
//
// Takes one angle triple per cycle while the pipeline advances and returns the
// quaternion. Three identical lanes (roll, pitch, yaw) each reduce their angle,
// convert it to radians and run a CORDIC with one register per iteration, which
// sets most of the latency; a five-stage multiplier tree then forms the four
// components. The whole pipeline advances together and holds only while the
// output word is waiting to be taken, so a new word is accepted every cycle
// whenever the output side is ready or the output register is empty.
module euler_degrees_to_quaternion import e2q_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // roll_deg[26:0], pitch_deg[53:27], yaw_deg[80:54]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // quat_scalar[17:0], quat_i[35:18], quat_j[53:36],
                                      // quat_k[71:54]
);

  localparam int LAT = CORDIC_STAGES + 10;

  logic           ce;
  logic [LAT-1:0] vld;
  sc_t            sc_roll, sc_pitch, sc_yaw;
  quat_t          quat;

  assign ce            = !vld[LAT-1] || m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = vld[LAT-1];
  assign m_axis_tdata  = {quat.k, quat.j, quat.i, quat.w};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  e2q_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .ce(ce), .angle(s_axis_tdata[IN_W-1:0]), .sc(sc_roll)
  );

  e2q_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .ce(ce), .angle(s_axis_tdata[2*IN_W-1:IN_W]), .sc(sc_pitch)
  );

  e2q_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .ce(ce), .angle(s_axis_tdata[3*IN_W-1:2*IN_W]), .sc(sc_yaw)
  );

  e2q_merge u_merge (
    .clk(clk), .ce(ce), .roll(sc_roll), .pitch(sc_pitch), .yaw(sc_yaw), .quat(quat)
  );

  localparam logic signed [OUT_W-1:0] ONE = OUT_W'(1 << FRAC_BITS);

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (quat.w <= ONE) && (quat.w >= -ONE) && (quat.i <= ONE)
      && (quat.i >= -ONE) && (quat.j <= ONE) && (quat.j >= -ONE)
      && (quat.k <= ONE) && (quat.k >= -ONE))
    else $error("quaternion component beyond saturation limit");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !ce |=> $stable(vld))
    else $error("pipeline moved while stalled");

  a_rise_after_advance: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(ce) && $past(vld[LAT-2]))
    else $error("output became valid without an advancing item");

endmodule

>>> rtl/e2q_lane.sv
// One angle lane: range reduction, degrees to radians, pipelined CORDIC, quadrant fixup.
module e2q_lane import e2q_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                   clk,
  input  logic                   ce,
  input  logic signed [IN_W-1:0] angle,
  output sc_t                    sc
);

  localparam logic signed [IN_W:0] P1 = (IN_W+1)'(PERIOD);
  localparam logic signed [IN_W:0] P2 = (IN_W+1)'(2 * PERIOD);
  localparam logic [IN_W-2:0] T1 = (IN_W-1)'(HALF_Q);
  localparam logic [IN_W-2:0] T3 = (IN_W-1)'(3 * HALF_Q);
  localparam logic [IN_W-2:0] T5 = (IN_W-1)'(5 * HALF_Q);
  localparam logic [IN_W-2:0] T7 = (IN_W-1)'(7 * HALF_Q);
  localparam logic signed [IN_W-1:0] Q1 = IN_W'(QUARTER);
  localparam logic signed [IN_W-1:0] Q2 = IN_W'(2 * QUARTER);
  localparam logic signed [IN_W-1:0] Q3 = IN_W'(3 * QUARTER);
  localparam logic signed [IN_W-1:0] Q4 = IN_W'(4 * QUARTER);
  localparam int PH_W = R_W + D2R_HI_W + 1;
  localparam int PL_W = R_W + D2R_SPLIT + 1;
  localparam int PR_W = ANG_W + RAD_SHIFT + 1;

  // Stage 1: reduce modulo the 720 degree period.
  logic signed [IN_W:0] ext;
  logic signed [IN_W:0] m_full;
  logic [IN_W-2:0]      m;

  assign ext = (IN_W+1)'(angle);

  always_comb begin
    priority if (ext < -P1) m_full = ext + P2;
    else if (ext < 0)       m_full = ext + P1;
    else if (ext >= P1)     m_full = ext - P1;
    else                    m_full = ext;
  end

  always_ff @(posedge clk) begin
    if (ce) m <= m_full[IN_W-2:0];
  end

  // Stage 2: nearest quadrant and remainder.
  logic signed [IN_W-1:0] m_s;
  logic signed [IN_W-1:0] r_full;
  logic [1:0]             q_next;
  logic signed [R_W-1:0]  r;
  logic [1:0]             q2;

  assign m_s = IN_W'(m);

  always_comb begin
    priority if (m < T1) begin q_next = 2'd0; r_full = m_s;      end
    else if (m < T3)     begin q_next = 2'd1; r_full = m_s - Q1; end
    else if (m < T5)     begin q_next = 2'd2; r_full = m_s - Q2; end
    else if (m < T7)     begin q_next = 2'd3; r_full = m_s - Q3; end
    else                 begin q_next = 2'd0; r_full = m_s - Q4; end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      r  <= r_full[R_W-1:0];
      q2 <= q_next;
    end
  end

  // Stage 3: two partial products of the radian conversion.
  logic signed [PH_W-1:0] ph;
  logic signed [PL_W-1:0] pl;
  logic [1:0]             q3;

  always_ff @(posedge clk) begin
    if (ce) begin
      ph <= PH_W'(r) * PH_W'($signed({1'b0, D2R_HI}));
      pl <= PL_W'(r) * PL_W'($signed({1'b0, D2R_LO}));
      q3 <= q2;
    end
  end

  // Stage 4: combine, round half up to Q30.
  logic signed [PR_W-1:0]  prod;
  logic signed [ANG_W-1:0] z4;
  logic [1:0]              q4;

  assign prod = (PR_W'(ph) <<< D2R_SPLIT) + PR_W'(pl)
              + (PR_W'(1) <<< (RAD_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (ce) begin
      z4 <= prod[RAD_SHIFT+ANG_W-1:RAD_SHIFT];
      q4 <= q3;
    end
  end

  // CORDIC rotation, one register stage per iteration.
  logic signed [ANG_W-1:0] rx [CORDIC_STAGES];
  logic signed [ANG_W-1:0] ry [CORDIC_STAGES];
  logic signed [ANG_W-1:0] rz [CORDIC_STAGES];
  logic [1:0]              rq [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [ANG_W-1:0] xi, yi, zi;
    logic [1:0]              qi;
    if (i == 0) begin : g_first
      assign xi = ANG_W'(CORDIC_INIT_X);
      assign yi = '0;
      assign zi = z4;
      assign qi = q4;
    end else begin : g_rest
      assign xi = rx[i-1];
      assign yi = ry[i-1];
      assign zi = rz[i-1];
      assign qi = rq[i-1];
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        if (!zi[ANG_W-1]) begin
          rx[i] <= xi - (yi >>> i);
          ry[i] <= yi + (xi >>> i);
          rz[i] <= zi - ANG_W'(atan_q30(i));
        end else begin
          rx[i] <= xi + (yi >>> i);
          ry[i] <= yi - (xi >>> i);
          rz[i] <= zi + ANG_W'(atan_q30(i));
        end
        rq[i] <= qi;
      end
    end
  end

  // Quadrant fixup.
  logic signed [ANG_W-1:0] fx, fy;
  sc_t                     sc_next;

  assign fx = rx[CORDIC_STAGES-1];
  assign fy = ry[CORDIC_STAGES-1];

  always_comb begin
    unique case (rq[CORDIC_STAGES-1])
      2'd0: begin sc_next.c = fx[SC_W-1:0];    sc_next.s = fy[SC_W-1:0];    end
      2'd1: begin sc_next.c = -fy[SC_W-1:0];   sc_next.s = fx[SC_W-1:0];    end
      2'd2: begin sc_next.c = -fx[SC_W-1:0];   sc_next.s = -fy[SC_W-1:0];   end
      default: begin sc_next.c = fy[SC_W-1:0]; sc_next.s = -fx[SC_W-1:0];   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ce) sc <= sc_next;
  end

endmodule

>>> rtl/e2q_merge.sv
// Merge stage: triple products of the three lanes' half-angle sines and cosines.
module e2q_merge import e2q_pkg::*; (
  input  logic  clk,
  input  logic  ce,
  input  sc_t   roll,
  input  sc_t   pitch,
  input  sc_t   yaw,
  output quat_t quat
);

  localparam int P_W = 2 * SC_W;
  localparam int S_W = P_W + 1;
  localparam int F_SH = 60 - FRAC_BITS;
  localparam int V_W = S_W - F_SH;
  localparam logic signed [V_W-1:0] ONE = V_W'(1 << FRAC_BITS);

  function automatic logic signed [OUT_W-1:0] finish(input logic signed [S_W-1:0] sum);
    logic signed [S_W-1:0] t;
    logic signed [V_W-1:0] v;
    t = sum + (S_W'(1) <<< (F_SH - 1));
    v = t[S_W-1:F_SH];
    if (v > ONE) v = ONE;
    else if (v < -ONE) v = -ONE;
    return v[OUT_W-1:0];
  endfunction

  // M1: pair products of roll and pitch.
  logic signed [P_W-1:0] pcc, pss, psc, pcs;
  sc_t                   yaw1, yaw2;

  always_ff @(posedge clk) begin
    if (ce) begin
      pcc  <= P_W'(roll.c) * P_W'(pitch.c);
      pss  <= P_W'(roll.s) * P_W'(pitch.s);
      psc  <= P_W'(roll.s) * P_W'(pitch.c);
      pcs  <= P_W'(roll.c) * P_W'(pitch.s);
      yaw1 <= yaw;
    end
  end

  // M2: round the pairs half up to Q30.
  logic signed [P_W-1:0]  rcc, rss, rsc, rcs;
  logic signed [SC_W-1:0] wcc, wss, wsc, wcs;

  assign rcc = (pcc + (P_W'(1) <<< 29)) >>> 30;
  assign rss = (pss + (P_W'(1) <<< 29)) >>> 30;
  assign rsc = (psc + (P_W'(1) <<< 29)) >>> 30;
  assign rcs = (pcs + (P_W'(1) <<< 29)) >>> 30;

  always_ff @(posedge clk) begin
    if (ce) begin
      wcc  <= rcc[SC_W-1:0];
      wss  <= rss[SC_W-1:0];
      wsc  <= rsc[SC_W-1:0];
      wcs  <= rcs[SC_W-1:0];
      yaw2 <= yaw1;
    end
  end

  // M3: products with the yaw terms, Q60.
  logic signed [P_W-1:0] t0, t1, t2, t3, t4, t5, t6, t7;

  always_ff @(posedge clk) begin
    if (ce) begin
      t0 <= P_W'(wcc) * P_W'(yaw2.c);
      t1 <= P_W'(wss) * P_W'(yaw2.s);
      t2 <= P_W'(wsc) * P_W'(yaw2.c);
      t3 <= P_W'(wcs) * P_W'(yaw2.s);
      t4 <= P_W'(wcs) * P_W'(yaw2.c);
      t5 <= P_W'(wsc) * P_W'(yaw2.s);
      t6 <= P_W'(wcc) * P_W'(yaw2.s);
      t7 <= P_W'(wss) * P_W'(yaw2.c);
    end
  end

  // M4: sums.
  logic signed [S_W-1:0] sw, si, sj, sk;

  always_ff @(posedge clk) begin
    if (ce) begin
      sw <= S_W'(t0) + S_W'(t1);
      si <= S_W'(t2) - S_W'(t3);
      sj <= S_W'(t4) + S_W'(t5);
      sk <= S_W'(t6) - S_W'(t7);
    end
  end

  // M5: round to the output format and saturate at plus or minus one.
  always_ff @(posedge clk) begin
    if (ce) begin
      quat.w <= finish(sw);
      quat.i <= finish(si);
      quat.j <= finish(sj);
      quat.k <= finish(sk);
    end
  end

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the Euler-angle to quaternion converter.
module tb_top;
  import e2q_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int LATENCY    = 26;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;   // roll_deg[26:0], pitch_deg[53:27], yaw_deg[80:54]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // quat_scalar[17:0], quat_i[35:18], quat_j[53:36], quat_k[71:54]

  logic [71:0] quat_queue[$];
  bit          failed;
  bit          hold_off;
  int          idle_cycles;

  euler_degrees_to_quaternion uut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Round half up of v / 2^s; >>> on longint is arithmetic.
  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // Cosine and sine (Q30) of half the given full angle.
  function automatic void half_angle_sincos(input logic [IN_W-1:0] raw, output longint c,
                                            output longint s);
    longint full, m, q, r, z, x, y, dx, dy;
    full = longint'($signed(raw));
    m = full % longint'(PERIOD);
    if (m < 0) m += PERIOD;
    q = (m + HALF_Q) / QUARTER;
    r = m - q * QUARTER;
    z = rnd_shift(r * 64'sd19190098069, FRAC_BITS + 11);
    x = 64'sh26DD3B6A;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q30(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q30(i));
      end
    end
    case (q & 3)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint prod3(longint a, longint b, longint c);
    return rnd_shift(a * b, 30) * c;
  endfunction

  function automatic logic [OUT_W-1:0] to_component(longint q60);
    longint v;
    v = rnd_shift(q60, 60 - FRAC_BITS);
    if (v > (64'sd1 <<< FRAC_BITS)) v = 64'sd1 <<< FRAC_BITS;
    if (v < -(64'sd1 <<< FRAC_BITS)) v = -(64'sd1 <<< FRAC_BITS);
    return v[OUT_W-1:0];
  endfunction

  function automatic logic [71:0] predict_quat(logic [87:0] word);
    longint cr, sr, cp, sp, cy, sy;
    half_angle_sincos(word[26:0], cr, sr);
    half_angle_sincos(word[53:27], cp, sp);
    half_angle_sincos(word[80:54], cy, sy);
    return {to_component(prod3(cr, cp, sy) - prod3(sr, sp, cy)),
            to_component(prod3(cr, sp, cy) + prod3(sr, cp, sy)),
            to_component(prod3(sr, cp, cy) - prod3(cr, sp, sy)),
            to_component(prod3(cr, cp, cy) + prod3(sr, sp, sy))};
  endfunction

  // Valid stays high from one word to the next when there is no gap.
  task automatic send_angles(input logic [IN_W-1:0] roll, pitch, yaw);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  <= {7'd0, yaw, pitch, roll};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    quat_queue.push_back(predict_quat({7'd0, yaw, pitch, roll}));
    @(negedge clk);
  endtask

  function automatic logic [IN_W-1:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return IN_W'($urandom);
      1: return IN_W'(int'($urandom_range(0, 16)) * 45 * 65536 - 360 * 65536);
      default: return IN_W'(int'($urandom_range(0, 94371840)) - 47185920);
    endcase
  endfunction

  task automatic test_directed();
    logic [IN_W-1:0] edge_vals[10];
    edge_vals = '{27'd0, 27'd47185920, -27'sd47185920, 27'h3FFFFFF, 27'h4000000,
                  27'd5898240, 27'd2949120, -27'sd2949120, 27'd1, 27'h7FFFFFF};
    foreach (edge_vals[n]) send_angles(edge_vals[n], edge_vals[9 - n], edge_vals[(n + 3) % 10]);
    for (int n = 0; n < 8; n++)
      send_angles(IN_W'(n * 90 * 65536), IN_W'(-n * 45 * 65536), IN_W'(n * 180 * 65536));
    send_angles(27'h5555555, 27'h2AAAAAA, 27'h7FFFFFF);
  endtask

  task automatic test_random();
    for (int n = 0; n < 750; n++) send_angles(rand_angle(), rand_angle(), rand_angle());
  endtask

  // The receiver stops taking words for a long stretch so the pipeline fills up.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 80; n++) send_angles(rand_angle(), rand_angle(), rand_angle());
    join
  endtask

  // The receiver draws a wait for every word, then stays ready until the word is taken.
  always begin : receiver
    int wait_cycles;
    wait_cycles = $urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0;
    if (wait_cycles > 0 || hold_off) begin
      m_axis_tready <= 1'b0;
      repeat (wait_cycles) @(negedge clk);
      while (hold_off) @(negedge clk);
    end
    m_axis_tready <= 1'b1;
    do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    @(negedge clk);
  end

  always @(posedge clk) begin
    logic [71:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (quat_queue.size() == 0) begin
        $display("%0t: unexpected word %h", $time, m_axis_tdata);
        failed = 1'b1;
      end else begin
        want = quat_queue.pop_front();
        for (int f = 0; f < 4; f++)
          if (m_axis_tdata[f*18 +: 18] !== want[f*18 +: 18]) begin
            $display("%0t: component %0d expected %h actual %h", $time, f,
                     want[f*18 +: 18], m_axis_tdata[f*18 +: 18]);
            failed = 1'b1;
          end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** euler_degrees_to_quaternion: FAILED **");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    hold_off = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    s_axis_tvalid <= 1'b0;
    wait (quat_queue.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (!failed && quat_queue.size() == 0)
      $display("** euler_degrees_to_quaternion: PASSED **");
    else
      $display("** euler_degrees_to_quaternion: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
rtl/e2q_pkg.sv
rtl/e2q_lane.sv
rtl/e2q_merge.sv
rtl/euler_degrees_to_quaternion.sv
verif/tb_top.sv
